### sv/ssmd_pkg.sv
// Shared types, constants and the character decode table for the
// multiplexed seven-segment display driver. No dependencies.
package ssmd_pkg;

  localparam int DEFAULT_MAX_DIGITS = 4;

  // Widths fixed by the interface
  localparam int CHAR_W     = 8;
  localparam int SEG_W      = 8;
  localparam int LINES_W    = 4;
  localparam int BRIGHT_W   = 2;
  localparam int DIGITS_W   = 3;
  localparam int DUTY_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  // Wide enough for any digit count up to eight
  localparam int COUNT_W    = 4;

  localparam logic [CHAR_W-1:0]   BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0]   DOT_CHAR     = 8'd46;
  localparam logic [CHAR_W-1:0]   NUL_CHAR     = 8'd0;
  localparam logic [DUTY_W-1:0]   DUTY_RELOAD  = 3'd4;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 2'd2;
  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 3'd4;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS    = 1'b0,
    CFG_DIGITS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [LINES_W-1:0] digit_enable;
    logic [SEG_W-1:0]   segments;
    logic               lit;
  } ssmd_result_t;

  // Segments a..g in bits 0..6 for one character code
  function automatic logic [6:0] decode_char(input logic [CHAR_W-1:0] c);
    logic [6:0] seg;
    unique case (c) inside
      8'd0, 8'd48, 8'd79, 8'd206: seg = 7'h3F;
      8'd1, 8'd49:                seg = 7'h06;
      8'd2, 8'd50:                seg = 7'h5B;
      8'd3, 8'd51:                seg = 7'h4F;
      8'd4, 8'd52:                seg = 7'h66;
      8'd5, 8'd53, 8'd83:         seg = 7'h6D;
      8'd6, 8'd54:                seg = 7'h7D;
      8'd7, 8'd55:                seg = 7'h07;
      8'd8, 8'd56, 8'd194:        seg = 7'h7F;
      8'd9, 8'd57:                seg = 7'h6F;
      8'd65, 8'd192:              seg = 7'h77;
      8'd67:                      seg = 7'h39;
      8'd69:                      seg = 7'h79;
      8'd70:                      seg = 7'h71;
      8'd72, 8'd205:              seg = 7'h76;
      8'd74:                      seg = 7'h0E;
      8'd76:                      seg = 7'h38;
      8'd80, 8'd208:              seg = 7'h73;
      8'd85, 8'd86:               seg = 7'h3E;
      8'd98:                      seg = 7'h7C;
      8'd99:                      seg = 7'h58;
      8'd104:                     seg = 7'h74;
      8'd110, 8'd111:             seg = 7'h54;
      8'd114:                     seg = 7'h50;
      8'd193:                     seg = 7'h7B;
      8'd207:                     seg = 7'h37;
      default:                    seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

### sv/seven_segment_mux_display.sv
// Multiplexed seven-segment display driver, top level.
// Each accepted beat's result goes to the result register, or to the skid
// register while that stalls. Throughput: one input beat per cycle unless
// stalled; the two-entry stage keeps input open while one result waits.
// Reset (rst, synchronous): buffer blank, dots clear, duty counter at four,
// scan at digit 0, digit lines off, brightness 2, digits in use 4, no beats.
module seven_segment_mux_display #(
  parameter int MAX_DIGITS = ssmd_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_write,
  input  logic [ssmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic                             new_string,
  input  logic [ssmd_pkg::CHAR_W-1:0]      character,
  // Output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ssmd_pkg::LINES_W-1:0]     digit_enable,
  output logic [ssmd_pkg::SEG_W-1:0]       segments,
  output logic                             lit
);
  import ssmd_pkg::*;

  logic         accept;
  logic         out_busy;
  logic         skid_valid;
  ssmd_result_t result;
  ssmd_result_t out_beat;
  ssmd_result_t skid_beat;

  // Take a beat whenever the skid register is free
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  // The result register holds a beat that is not being taken this cycle
  assign out_busy = out_valid && out_stall;

  // All display state but the configuration registers updates in the core at
  // the accept edge; its result is a pure function of old state and the beat.
  ssmd_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (accept),
    .op         (op),
    .new_string (new_string),
    .character  (character),
    .result     (result)
  );

  // Output stage control: park a new beat in skid while the result
  // register is stalled, otherwise load the result register directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_busy) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (!out_busy) begin
      // Advance skid into the result register, or drop to empty
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_busy) begin
        skid_beat <= result;
      end else begin
        out_beat <= result;
      end
    end else if (!out_busy && skid_valid) begin
      out_beat <= skid_beat;
    end
  end

  assign digit_enable = out_beat.digit_enable;
  assign segments     = out_beat.segments;
  assign lit          = out_beat.lit;

endmodule

### sv/ssmd_core.sv
// Display state: configuration registers, character buffer, dot flags,
// duty counter and scan position. Depends on ssmd_pkg.
module ssmd_core #(
  parameter int MAX_DIGITS = ssmd_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ssmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             step,
  input  logic                             op,
  input  logic                             new_string,
  input  logic [ssmd_pkg::CHAR_W-1:0]      character,
  output ssmd_pkg::ssmd_result_t           result
);
  import ssmd_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int WP_W  = $clog2(MAX_DIGITS + 1);

  logic [BRIGHT_W-1:0] brightness;
  logic [DIGITS_W-1:0] digits_in_use;
  logic [CHAR_W-1:0]   char_buffer [MAX_DIGITS];
  logic [CHAR_W-1:0]   char_buffer_next [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] dot_flags, dot_flags_next;
  logic [WP_W-1:0]     write_pointer, write_pointer_next;
  logic [DUTY_W-1:0]   duty_counter, duty_counter_next;
  logic [IDX_W-1:0]    scan_digit, scan_digit_next;
  logic [LINES_W-1:0]  digit_lines, digit_lines_next;

  logic [COUNT_W-1:0]  n_used;
  logic [WP_W-1:0]     wp_base;
  logic                is_dot;
  logic [DUTY_W-1:0]   duty_dec;
  logic                fire;
  logic [IDX_W-1:0]    sd;
  logic [COUNT_W-1:0]  sd_inc;
  logic [SEG_W-1:0]    seg;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHT_RESET;
      digits_in_use <= DIGITS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BRIGHTNESS:    brightness    <= cfg_data[BRIGHT_W-1:0];
        CFG_DIGITS_IN_USE: digits_in_use <= cfg_data[DIGITS_W-1:0];
        default:           brightness    <= brightness;
      endcase
    end
  end

  // Clamp the digit count to 1..MAX_DIGITS
  always_comb begin
    if (digits_in_use == '0) begin
      n_used = COUNT_W'(1);
    end else if (COUNT_W'(digits_in_use) > COUNT_W'(MAX_DIGITS)) begin
      n_used = COUNT_W'(MAX_DIGITS);
    end else begin
      n_used = COUNT_W'(digits_in_use);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      char_buffer_next[k] = char_buffer[k];
    end
    dot_flags_next     = dot_flags;
    write_pointer_next = write_pointer;
    duty_counter_next  = duty_counter;
    scan_digit_next    = scan_digit;
    digit_lines_next   = digit_lines;
    wp_base  = new_string ? '0 : write_pointer;
    is_dot   = (character == DOT_CHAR) || (character == NUL_CHAR);
    duty_dec = duty_counter - 1'b1;
    fire     = (duty_dec == DUTY_W'(brightness));
    sd       = (COUNT_W'(scan_digit) >= n_used) ? '0 : scan_digit;
    sd_inc   = COUNT_W'(sd) + 1'b1;
    seg      = '0;

    if (op == OP_LOAD) begin
      if (new_string) begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
          char_buffer_next[k] = BLANK_CHAR;
        end
        dot_flags_next     = '0;
        write_pointer_next = '0;
      end
      if (is_dot) begin
        if (new_string) begin
          // A leading dot marks position 0 and skips it
          dot_flags_next[0]  = 1'b1;
          write_pointer_next = WP_W'(1);
        end else if (write_pointer != '0 &&
                     (COUNT_W'(write_pointer) - 1'b1) < n_used) begin
          dot_flags_next[IDX_W'(write_pointer - 1'b1)] = 1'b1;
        end
      end else if (COUNT_W'(wp_base) < n_used) begin
        char_buffer_next[IDX_W'(wp_base)] = character;
        write_pointer_next = wp_base + 1'b1;
      end
    end else begin
      duty_counter_next = duty_dec;
      if (fire) begin
        for (int i = 0; i < LINES_W; i++) begin
          digit_lines_next[i] = (COUNT_W'(sd) == COUNT_W'(i));
        end
        seg = {dot_flags[sd], decode_char(char_buffer[sd])};
        duty_counter_next = DUTY_RELOAD;
        scan_digit_next   = (sd_inc >= n_used) ? '0 : IDX_W'(sd_inc);
      end
    end

    result.digit_enable = digit_lines_next;
    result.segments     = seg;
    result.lit          = (op == OP_TICK) && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
        char_buffer[k] <= BLANK_CHAR;
      end
      dot_flags     <= '0;
      write_pointer <= '0;
      duty_counter  <= DUTY_RELOAD;
      scan_digit    <= '0;
      digit_lines   <= '0;
    end else if (step) begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
        char_buffer[k] <= char_buffer_next[k];
      end
      dot_flags     <= dot_flags_next;
      write_pointer <= write_pointer_next;
      duty_counter  <= duty_counter_next;
      scan_digit    <= scan_digit_next;
      digit_lines   <= digit_lines_next;
    end
  end

endmodule

### sv/ssmd_checker.sv
// Port-level checks for the seven-segment display driver, bound to the
// top level. Depends on ssmd_pkg.
module ssmd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ssmd_pkg::LINES_W-1:0] digit_enable,
  input logic [ssmd_pkg::SEG_W-1:0]   segments,
  input logic                         lit
);
  import ssmd_pkg::*;

  // Every accepted beat leaves a result waiting on the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted beat produced no result");

  // Segments stay dark unless a digit was lit
  a_dark_unless_lit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !lit) |-> (segments == '0))
    else $error("segments driven on an unlit beat");

  // At most one digit line is active
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(digit_enable))
    else $error("more than one digit line active");

  // Reset empties the output stage and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output stage not empty after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(digit_enable) &&
                                  $stable(segments) && $stable(lit)))
    else $error("stalled result changed");

endmodule

bind seven_segment_mux_display ssmd_checker u_ssmd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .digit_enable (digit_enable),
  .segments     (segments),
  .lit          (lit)
);
